[sv/sobel_edge_filter_stream_unit_defines.svh]
// Assertion macros for the Sobel edge filter stream unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SOBEL_EDGE_FILTER_STREAM_UNIT_DEFINES_SVH
`define SOBEL_EDGE_FILTER_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, reported through $error
`define SEF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported through $error
`define SEF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sef_pkg.sv]
// Shared types, constants and helper functions for the Sobel edge filter stream unit.
// No dependencies; imported by the window cell, the result queue and the top level.
package sef_pkg;

   // Configuration register file
   localparam int CFG_W = 12;
   typedef logic [CFG_W-1:0] cfg_word_type;

   typedef enum logic {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam cfg_word_type LINE_WIDTH_RESET   = 12'd640;
   localparam cfg_word_type FRAME_HEIGHT_RESET = 12'd480;
   localparam cfg_word_type MIN_DIM            = 12'd3;

   // BT.709 luma weights in Q0.16, summing to 65536
   localparam logic [15:0] COEF_BLUE  = 16'd4732;
   localparam logic [15:0] COEF_GREEN = 16'd46871;
   localparam logic [15:0] COEF_RED   = 16'd13933;

   typedef logic [7:0] gray_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       row_end;
      logic       frame_end;
   } rsp_payload_type;

   // One column of the 3x3 window
   typedef struct packed {
      gray_type top;
      gray_type mid;
      gray_type bot;
   } window_col_type;

   // One entry of the line store: the two previous rows at a column
   typedef struct packed {
      gray_type older;
      gray_type newer;
   } line_pair_type;

   // Result queue push from the pipeline
   typedef struct packed {
      logic            first_valid;
      logic            second_valid;
      rsp_payload_type first;
      rsp_payload_type second;
   } fifo_push_type;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // a + 2b + c over three gray taps
   function automatic logic [9:0] tap_sum(gray_type a, gray_type b, gray_type c);
      return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   // |pos - neg| clamped to 255
   function automatic gray_type grad_clamp(logic [9:0] pos, logic [9:0] neg);
      logic [9:0] mag;
      mag = (pos >= neg) ? (pos - neg) : (neg - pos);
      return (mag > 10'd255) ? 8'hFF : mag[7:0];
   endfunction

endpackage

[sv/sef_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line store.
module sef_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sef_window_cell.sv]
// One column cell of the 3x3 window chain: holds three gray taps and passes them on.
// Depends on sef_pkg for the window column type.
module sef_window_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  sef_pkg::window_col_type load_col,
   output sef_pkg::window_col_type held_col
);

   import sef_pkg::*;

   window_col_type col_ff;
   window_col_type col_in;

   // Take the neighbour's column on every shift, hold otherwise
   always_comb begin
      col_in = shift_en ? load_col : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign held_col = col_ff;

endmodule

[sv/sef_result_fifo.sv]
// Result queue: up to two pushes and one pop per cycle, registered entries.
// Depends on sef_pkg for payload, push types and queue depth.
module sef_result_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  sef_pkg::fifo_push_type             push,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sef_pkg::rsp_payload_type           rsp_data,
   output logic [sef_pkg::FIFO_CNT_W-1:0]     count
);

   import sef_pkg::*;

   rsp_payload_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic [1:0]            push_n;
   logic                  pop;

   assign pop         = (count_ff != '0) && !rsp_stall;
   assign push_n      = {push.first_valid & push.second_valid,
                         push.first_valid & ~push.second_valid};
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transactions
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[sv/sobel_edge_filter_stream_unit.sv]
// Top level of the Sobel edge filter stream unit: grey conversion, line store, window, output.
// Depends on sef_pkg, sef_ram, sef_window_cell, sef_result_fifo and the assertion macro header.
//
// Takes BGR pixels in raster order, one per clock while not stalled, converts each to BT.709
// grey and slides a 3x3 window (three column cells fed from a two-row line store) across the
// image. Each interior row gives one result per column, saturated |Gx| + |Gy|, with 0 on the
// two border columns; the last result of a row carries row_end and the last of the frame
// frame_end. An accepted pixel is read from the line store into the stage 1 registers, then
// shifts into the window with its stage 2 flags, and its gradient is then written into the
// result queue, which offers its results on the output in order. The input takes one pixel
// per clock as long as the eight-entry result queue has room for two more results beyond
// those already in flight; a pixel at the end of a row gives two results, so with a
// draining output the input sustains one pixel per cycle and stalls only when the output
// side holds results back. The line store needs no clearing pass after reset.
`include "sobel_edge_filter_stream_unit_defines.svh"

module sobel_edge_filter_stream_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  sef_pkg::csr_index_type   csr_index,
   input  sef_pkg::cfg_word_type    csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sef_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sef_pkg::rsp_payload_type rsp_data
);

   import sef_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = CW + 1;

   // Configuration registers
   cfg_word_type line_width_ff, line_width_in;
   cfg_word_type frame_height_ff, frame_height_in;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_WIDTH:   line_width_in   = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Effective geometry
   logic [EW-1:0] width_eff;
   logic [CW-1:0] col_last;
   cfg_word_type  row_last;

   always_comb begin
      if (line_width_ff < MIN_DIM) begin
         width_eff = EW'(3);
      end else if (int'(line_width_ff) > MAX_WIDTH) begin
         width_eff = EW'(MAX_WIDTH);
      end else begin
         width_eff = EW'(line_width_ff);
      end
      col_last = CW'(width_eff - 1'b1);
      row_last = (frame_height_ff < MIN_DIM) ? (MIN_DIM - 1'b1) : (frame_height_ff - 1'b1);
   end

   // Stage 0: position, grey conversion, line store read
   logic          accept;
   logic [CW-1:0] col_ff, col_in;
   cfg_word_type  row_ff, row_in;
   logic [CW-1:0] col0;
   cfg_word_type  row0;
   logic          emit0, two0, ge2_0, fe0;
   logic [23:0]   luma_sum;
   gray_type      gray0;

   assign accept = req_valid && !req_stall;

   always_comb begin
      col0  = req_data.frame_start ? '0 : ((col_ff > col_last) ? col_last : col_ff);
      row0  = req_data.frame_start ? '0 : row_ff;
      emit0 = (row0 >= 12'd2) && (row0 <= row_last) && (col0 != '0);
      two0  = (col0 == col_last);
      ge2_0 = (col0 >= CW'(2));
      fe0   = (row0 == row_last);

      luma_sum = 24'(COEF_BLUE)  * 24'(req_data.blue)
               + 24'(COEF_GREEN) * 24'(req_data.green)
               + 24'(COEF_RED)   * 24'(req_data.red);
      gray0    = luma_sum[23:16];

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col0 == col_last) begin
            col_in = '0;
            row_in = (row0 >= row_last) ? '0 : (row0 + 1'b1);
         end else begin
            col_in = col0 + 1'b1;
            row_in = row0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1 registers
   logic          s1_valid_ff;
   logic          s1_emit_ff, s1_two_ff, s1_ge2_ff, s1_fe_ff;
   logic [CW-1:0] s1_col_ff;
   gray_type      s1_gray_ff;
   logic          fwd_hit_ff, fwd_hit_in;
   line_pair_type fwd_data_ff;

   // Line store: one entry per column holds the two previous rows
   line_pair_type ram_rd_data;
   line_pair_type ram_wr_data;
   line_pair_type line_rd;

   sef_ram #(
      .WIDTH ($bits(line_pair_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col0),
      .rd_data (ram_rd_data)
   );

   // Forward the store written in the cycle of a read at the same column
   assign fwd_hit_in  = accept && s1_valid_ff && (s1_col_ff == col0);
   assign line_rd     = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_data = '{older: line_rd.newer, newer: s1_gray_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wr_data;
      if (accept) begin
         s1_col_ff  <= col0;
         s1_gray_ff <= gray0;
         s1_emit_ff <= emit0;
         s1_two_ff  <= two0;
         s1_ge2_ff  <= ge2_0;
         s1_fe_ff   <= fe0;
      end
   end

   // Window chain: index 2 is the right column, index 0 the left
   window_col_type win_load [3];
   window_col_type win_col  [3];

   assign win_load[2] = '{top: line_rd.older, mid: line_rd.newer, bot: s1_gray_ff};

   for (genvar i = 0; i < 3; i++) begin : g_window
      if (i < 2) begin : g_link
         assign win_load[i] = win_col[i+1];
      end
      sef_window_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_valid_ff),
         .load_col (win_load[i]),
         .held_col (win_col[i])
      );
   end

   // Stage 2: result flags ride alongside the shifted window
   logic s2_emit_ff, s2_two_ff, s2_ge2_ff, s2_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_two_ff <= s1_two_ff;
      s2_ge2_ff <= s1_ge2_ff;
      s2_fe_ff  <= s1_fe_ff;
   end

   // Gradients and saturated sum
   gray_type      grad_x, grad_y;
   logic [8:0]    grad_sum;
   gray_type      edge_sat;
   fifo_push_type push;

   always_comb begin
      grad_x   = grad_clamp(tap_sum(win_col[2].top, win_col[2].mid, win_col[2].bot),
                            tap_sum(win_col[0].top, win_col[0].mid, win_col[0].bot));
      grad_y   = grad_clamp(tap_sum(win_col[0].top, win_col[1].top, win_col[2].top),
                            tap_sum(win_col[0].bot, win_col[1].bot, win_col[2].bot));
      grad_sum = {1'b0, grad_x} + {1'b0, grad_y};
      edge_sat = grad_sum[8] ? 8'hFF : grad_sum[7:0];

      push.first_valid  = s2_emit_ff;
      push.second_valid = s2_emit_ff && s2_two_ff;
      push.first        = '{edge_value: (s2_ge2_ff ? edge_sat : 8'd0),
                            row_end: 1'b0, frame_end: 1'b0};
      push.second       = '{edge_value: 8'd0, row_end: 1'b1, frame_end: s2_fe_ff};
   end

   // Result queue
   logic [FIFO_CNT_W-1:0] fifo_count;

   sef_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

   // Hold the input unless the queue has room for all results in flight plus two
   logic [1:0] s1_nres, s2_nres;
   logic [4:0] credit_need;

   always_comb begin
      s1_nres     = {s1_valid_ff & s1_emit_ff & s1_two_ff,
                     s1_valid_ff & s1_emit_ff & ~s1_two_ff};
      s2_nres     = {s2_emit_ff & s2_two_ff, s2_emit_ff & ~s2_two_ff};
      credit_need = 5'(fifo_count) + 5'(s1_nres) + 5'(s2_nres) + 5'd2;
      req_stall   = (credit_need > 5'(FIFO_DEPTH));
   end

   // Checks
   `SEF_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, fifo_count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overrun")
   `SEF_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted pixel lost before line store stage")
   `SEF_ASSERT_IMPLY(a_frame_end_on_row_end, clock, reset, rsp_valid && rsp_data.frame_end, rsp_data.row_end, "frame end without row end")
   `SEF_ASSERT_IMPLY(a_row_end_border, clock, reset, rsp_valid && rsp_data.row_end, rsp_data.edge_value == 8'd0, "row end result not a border zero")

endmodule
